>>> hdl/ffba_pkg.sv
package ffba_pkg;

	// Fixed field widths of the request, response and configuration beats.
	localparam int unsigned SIZE_W   = 21;
	localparam int unsigned STATUS_W = 2;

	// Defaults for the top-level parameters.
	localparam int unsigned DEF_MAX_CHUNKS     = 64;
	localparam int unsigned DEF_HEADER_BYTES   = 24;
	localparam int unsigned DEF_HEAP_ADDR_BITS = 20;

	// Reset value of the heap size register.
	localparam logic [SIZE_W-1:0] REGION_SIZE_RESET = SIZE_W'(65536);

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 2'd3;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} ffba_state_t;

	// Per-cell control group.
	typedef struct packed {
		logic shift;
		logic ent_we;
		logic flag_we;
		logic flag_value;
	} ffba_cell_ctl_t;

endpackage

>>> hdl/ffba_ifs.sv
interface ffba_req_if import ffba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [SIZE_W-1:0] request_size;
	logic [SIZE_W-1:0] free_address;

	modport source (output valid, command, request_size, free_address, input ready);
	modport sink (input valid, command, request_size, free_address, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SIZE_W-1:0]   payload_address;
	logic [STATUS_W-1:0] status;

	modport source (output valid, payload_address, status, input ready);
	modport sink (input valid, payload_address, status, output ready);
endinterface

interface ffba_cfg_if import ffba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] region_size;

	modport source (output valid, region_size, input ready);
	modport sink (input valid, region_size, output ready);
endinterface

>>> hdl/ffba_cell.sv
module ffba_cell import ffba_pkg::*; #(
	parameter int unsigned HEAP_ADDR_BITS = DEF_HEAP_ADDR_BITS
) (
	input  logic                      clk,
	input  ffba_cell_ctl_t            ctl,
	input  logic [HEAP_ADDR_BITS-1:0] nb_start,
	input  logic [SIZE_W-1:0]         nb_length,
	input  logic                      nb_free,
	input  logic [HEAP_ADDR_BITS-1:0] wr_start,
	input  logic [SIZE_W-1:0]         wr_length,
	output logic [HEAP_ADDR_BITS-1:0] start,
	output logic [SIZE_W-1:0]         length,
	output logic                      is_free
);

	logic [HEAP_ADDR_BITS-1:0] start_q;
	logic [SIZE_W-1:0]         length_q;
	logic                      free_q;

	// One table entry: takes its neighbor's entry while the ring rotates,
	// otherwise accepts a new chunk or a new free flag.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			start_q  <= nb_start;
			length_q <= nb_length;
			free_q   <= nb_free;
		end else if (ctl.ent_we) begin
			start_q  <= wr_start;
			length_q <= wr_length;
			free_q   <= 1'b0;
		end else if (ctl.flag_we) begin
			free_q <= ctl.flag_value;
		end
	end

	assign start   = start_q;
	assign length  = length_q;
	assign is_free = free_q;

endmodule

>>> hdl/first_fit_bump_allocator.sv
// First-fit heap allocator with a bump pointer.
// Channels: req (sink) carries command, request_size and free_address; rsp
// (source) returns payload_address and status, one response beat for every
// request beat; cfg (sink) writes the region size and is always ready.
// The chunk table is a ring of MAX_CHUNKS cells. For each request the ring
// rotates one full lap, one entry per cycle past a single compare unit at
// the head, so the first-fit search and the free lookup see every entry.
// A request is accepted in S_IDLE, rotated through the ring in S_SCAN and
// loads the response register in S_DONE; the next request is accepted only
// after the return to S_IDLE, so requests do not overlap. The full lap of
// the ring sets the time that each request takes.
// Reset clears the chunk count, the break offset and the response valid flag,
// and sets the region size to 65536. Table contents need no clearing, because
// only entries below the chunk count are ever looked at.
// When the receiver stalls, the response waits in its register and a new
// request may still be accepted and scanned; it then holds at the end of its
// scan until the response register is free.
module first_fit_bump_allocator import ffba_pkg::*; #(
	parameter int unsigned MAX_CHUNKS     = DEF_MAX_CHUNKS,
	parameter int unsigned HEADER_BYTES   = DEF_HEADER_BYTES,
	parameter int unsigned HEAP_ADDR_BITS = DEF_HEAP_ADDR_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	ffba_req_if.sink   req,
	ffba_rsp_if.source rsp,
	ffba_cfg_if.sink   cfg
);

	localparam int unsigned IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);
	localparam int unsigned CMP_W = 34;
	localparam int unsigned SUM_W = (HEAP_ADDR_BITS + 8 > SIZE_W) ?
		HEAP_ADDR_BITS + 8 : SIZE_W;

	ffba_state_t state_q, state_d;

	logic                      cmd_q;
	logic [SIZE_W-1:0]         req_size_q;
	logic [SIZE_W-1:0]         free_addr_q;
	logic [IDX_W-1:0]          scan_idx_q;
	logic                      found_q;
	logic [IDX_W-1:0]          hit_idx_q;
	logic [HEAP_ADDR_BITS-1:0] hit_start_q;
	logic [CNT_W-1:0]          count_q;
	logic [SIZE_W-1:0]         brk_q;
	logic [SIZE_W-1:0]         region_size_q;
	logic                      rsp_valid_q;
	logic [SIZE_W-1:0]         rsp_addr_q;
	logic [STATUS_W-1:0]       rsp_status_q;

	logic accept, scan_en, scan_last, commit;

	// Ring of cells.
	logic [HEAP_ADDR_BITS-1:0] c_start  [MAX_CHUNKS];
	logic [SIZE_W-1:0]         c_length [MAX_CHUNKS];
	logic                      c_free   [MAX_CHUNKS];

	logic                      ent_we, flag_we, flag_val;
	logic [IDX_W-1:0]          wr_idx;
	logic [HEAP_ADDR_BITS-1:0] wr_start;
	logic [CNT_W-1:0]          count_d;
	logic [SIZE_W-1:0]         brk_d;
	logic [SIZE_W-1:0]         rsp_addr_d;
	logic [STATUS_W-1:0]       rsp_status_d;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_CHUNKS; gi++) begin : g_cell
			localparam int unsigned NXT = (gi + 1) % MAX_CHUNKS;
			ffba_cell_ctl_t ctl;

			assign ctl.shift      = scan_en;
			assign ctl.ent_we     = ent_we && (wr_idx == IDX_W'(gi));
			assign ctl.flag_we    = flag_we && (wr_idx == IDX_W'(gi));
			assign ctl.flag_value = flag_val;

			ffba_cell #(
				.HEAP_ADDR_BITS(HEAP_ADDR_BITS)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.nb_start (c_start[NXT]),
				.nb_length(c_length[NXT]),
				.nb_free  (c_free[NXT]),
				.wr_start (wr_start),
				.wr_length(req_size_q),
				.start    (c_start[gi]),
				.length   (c_length[gi]),
				.is_free  (c_free[gi])
			);
		end
	endgenerate

	// Compare unit at the head of the ring.
	logic [SUM_W-1:0] head_sum;
	logic [SIZE_W-1:0] head_payload;
	logic head_valid, head_fit, head_match;

	assign head_sum     = SUM_W'(c_start[0]) + SUM_W'(HEADER_BYTES);
	assign head_payload = head_sum[SIZE_W-1:0];
	assign head_valid   = CNT_W'(scan_idx_q) < count_q;
	assign head_fit     = head_valid && c_free[0] && (c_length[0] >= req_size_q);
	assign head_match   = head_valid && (head_payload == free_addr_q);
	assign scan_last    = scan_idx_q == IDX_W'(MAX_CHUNKS - 1);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		accept  = 1'b0;
		scan_en = 1'b0;
		commit  = 1'b0;
		case (state_q)
			S_IDLE: accept = req.valid;
			S_SCAN: scan_en = 1'b1;
			S_DONE: commit = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// Decision at the end of the lap: reuse, append, or free.
	logic [CMP_W-1:0] need, limit, cap;
	logic [SUM_W-1:0] hit_sum;
	logic [CMP_W-1:0] brk_sum;

	assign need    = CMP_W'(brk_q) + CMP_W'(HEADER_BYTES) + CMP_W'(req_size_q);
	assign cap     = CMP_W'(1) << HEAP_ADDR_BITS;
	assign limit   = (CMP_W'(region_size_q) < cap) ? CMP_W'(region_size_q) : cap;
	assign hit_sum = SUM_W'(hit_start_q) + SUM_W'(HEADER_BYTES);
	assign brk_sum = CMP_W'(brk_q) + CMP_W'(HEADER_BYTES);
	assign wr_start = HEAP_ADDR_BITS'(brk_q);

	always_comb begin
		ent_we       = 1'b0;
		flag_we      = 1'b0;
		flag_val     = 1'b0;
		wr_idx       = hit_idx_q;
		count_d      = count_q;
		brk_d        = brk_q;
		rsp_addr_d   = '0;
		rsp_status_d = ST_OK;
		if (cmd_q == CMD_ALLOC) begin
			if (found_q) begin
				flag_we    = commit;
				flag_val   = 1'b0;
				rsp_addr_d = hit_sum[SIZE_W-1:0];
			end else if (need > limit) begin
				rsp_status_d = ST_EXHAUSTED;
			end else if (count_q >= CNT_W'(MAX_CHUNKS)) begin
				rsp_status_d = ST_TABLE_FULL;
			end else begin
				ent_we     = commit;
				wr_idx     = count_q[IDX_W-1:0];
				count_d    = count_q + CNT_W'(1);
				brk_d      = need[SIZE_W-1:0];
				rsp_addr_d = brk_sum[SIZE_W-1:0];
			end
		end else begin
			if (!found_q) begin
				rsp_status_d = ST_UNKNOWN;
			end else begin
				flag_we  = commit;
				flag_val = 1'b1;
				if (CNT_W'(hit_idx_q) + CNT_W'(1) == count_q) begin
					count_d = count_q - CNT_W'(1);
					brk_d   = SIZE_W'(hit_start_q);
				end
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			brk_q         <= '0;
			region_size_q <= REGION_SIZE_RESET;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) region_size_q <= cfg.region_size;
			if (commit) begin
				count_q     <= count_d;
				brk_q       <= brk_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, scan bookkeeping and response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= req.command;
			req_size_q  <= req.request_size;
			free_addr_q <= req.free_address;
			scan_idx_q  <= '0;
			found_q     <= 1'b0;
		end else if (scan_en) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (cmd_q == CMD_ALLOC) begin
				if (!found_q && head_fit) begin
					found_q     <= 1'b1;
					hit_idx_q   <= scan_idx_q;
					hit_start_q <= c_start[0];
				end
			end else if (head_match) begin
				found_q     <= 1'b1;
				hit_idx_q   <= scan_idx_q;
				hit_start_q <= c_start[0];
			end
		end
		if (commit) begin
			rsp_addr_q   <= rsp_addr_d;
			rsp_status_q <= rsp_status_d;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.payload_address = rsp_addr_q;
	assign rsp.status          = rsp_status_q;

endmodule
